// ===== hw/rtl/ots_pkg.sv =====
// Package for the operator token scanner: token kinds, result structs
// and the byte classification functions. No dependencies.
package ots_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

  localparam logic [7:0] GARBAGE_MIN = 8'h80;
  localparam logic [7:0] CTRL_LIMIT  = 8'h20;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  localparam offset_t OFF_ONE = offset_t'(1);

  localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

  typedef enum logic [5:0] {
    K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE, K_LBRACKET, K_RBRACKET,
    K_COMMA, K_SEMI, K_QUESTION, K_TILDE, K_CARET, K_DOT,
    K_PCT_EQ, K_PCT, K_PLUS_EQ, K_INC, K_PLUS, K_MINUS_EQ, K_DEC,
    K_ARROW, K_MINUS, K_STAR_EQ, K_POW, K_STAR, K_SLASH_EQ, K_SLASH,
    K_NE, K_BANG, K_EQ, K_ASSIGN, K_LE, K_SHL, K_LT, K_GE, K_SHR, K_GT,
    K_LAND, K_AMP, K_LOR, K_PIPE, K_SCOPE, K_COLON,
    K_RUN, K_BAD
  } kind_t;

  typedef struct packed {
    logic  ok;
    kind_t kind;
  } kind_hit_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] len;
    logic [7:0]  bad;
  } res_t;

  // one queue entry holds all results of one item (one or two)
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  function automatic logic [31:0] lo32(input offset_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic logic is_garbage(input logic [7:0] b);
    logic ctl;
    ctl = (b < CTRL_LIMIT) && (b != 8'h0A) && (b != 8'h0D) && (b != 8'h09);
    return (b >= GARBAGE_MIN) || ctl;
  endfunction

  function automatic logic is_lead(input logic [7:0] b);
    logic r;
    case (b) inside
      "%", "+", "-", "*", "/", "!", "=", "<", ">", "&", "|", ":": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_hit_t kind_alone(input logic [7:0] b);
    kind_hit_t h;
    h.ok = 1'b1;
    case (b)
      "(":     h.kind = K_LPAREN;
      ")":     h.kind = K_RPAREN;
      "{":     h.kind = K_LBRACE;
      "}":     h.kind = K_RBRACE;
      "[":     h.kind = K_LBRACKET;
      "]":     h.kind = K_RBRACKET;
      ",":     h.kind = K_COMMA;
      ";":     h.kind = K_SEMI;
      "?":     h.kind = K_QUESTION;
      "~":     h.kind = K_TILDE;
      "^":     h.kind = K_CARET;
      ".":     h.kind = K_DOT;
      "%":     h.kind = K_PCT;
      "+":     h.kind = K_PLUS;
      "-":     h.kind = K_MINUS;
      "*":     h.kind = K_STAR;
      "/":     h.kind = K_SLASH;
      "!":     h.kind = K_BANG;
      "=":     h.kind = K_ASSIGN;
      "<":     h.kind = K_LT;
      ">":     h.kind = K_GT;
      "&":     h.kind = K_AMP;
      "|":     h.kind = K_PIPE;
      ":":     h.kind = K_COLON;
      default: begin
        h.ok   = 1'b0;
        h.kind = K_BAD;
      end
    endcase
    return h;
  endfunction

  function automatic kind_hit_t kind_pair(input logic [7:0] lead, input logic [7:0] nb);
    kind_hit_t h;
    h.ok   = 1'b1;
    h.kind = K_BAD;
    case (lead)
      "%": if (nb == "=") h.kind = K_PCT_EQ; else h.ok = 1'b0;
      "+": begin
        if (nb == "=") h.kind = K_PLUS_EQ;
        else if (nb == "+") h.kind = K_INC;
        else h.ok = 1'b0;
      end
      "-": begin
        if (nb == "=") h.kind = K_MINUS_EQ;
        else if (nb == "-") h.kind = K_DEC;
        else if (nb == ">") h.kind = K_ARROW;
        else h.ok = 1'b0;
      end
      "*": begin
        if (nb == "=") h.kind = K_STAR_EQ;
        else if (nb == "*") h.kind = K_POW;
        else h.ok = 1'b0;
      end
      "/": if (nb == "=") h.kind = K_SLASH_EQ; else h.ok = 1'b0;
      "!": if (nb == "=") h.kind = K_NE; else h.ok = 1'b0;
      "=": if (nb == "=") h.kind = K_EQ; else h.ok = 1'b0;
      "<": begin
        if (nb == "=") h.kind = K_LE;
        else if (nb == "<") h.kind = K_SHL;
        else h.ok = 1'b0;
      end
      ">": begin
        if (nb == "=") h.kind = K_GE;
        else if (nb == ">") h.kind = K_SHR;
        else h.ok = 1'b0;
      end
      "&": if (nb == "&") h.kind = K_LAND; else h.ok = 1'b0;
      "|": if (nb == "|") h.kind = K_LOR; else h.ok = 1'b0;
      ":": if (nb == ":") h.kind = K_SCOPE; else h.ok = 1'b0;
      default: h.ok = 1'b0;
    endcase
    return h;
  endfunction

endpackage

// ===== hw/rtl/operator_token_scanner.sv =====
// Operator token scanner top level: front end, result queue, output stage.
// Depends on ots_pkg, ots_front, ots_queue, ots_emit.
//
// Usage:
//   Slave channel: one item per handshake. s_tuser[0] is the function
//   (0 = source byte in s_tdata[7:0], 1 = end of input, flushes a held
//   operator byte or an open garbage run).
//   Master channel: one token per handshake in m_tdata; m_tlast marks the
//   last result caused by an input item. An item gives zero, one or two
//   results; items that give none (held bytes, garbage inside a run) just
//   update state.
//   Throughput: one item per cycle while s_tready is high; the scanner
//   logic is combinational on the accepted byte, so only the output port
//   bounds the rate, at one result per cycle while m_tready is high.
//   A result is written to the queue, then loaded into the output stage.
//   A four-entry queue of per-item results separates input and output; a
//   stalled receiver fills it and then s_tready drops.
//   Reset (rst, synchronous): offset, held byte and run state cleared,
//   queue emptied, m_tvalid low.
module operator_token_scanner import ots_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] source_byte
  input  logic [0:0]  s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [5:0] token_kind, [37:6] token_start,
                                 // [69:38] token_length, [77:70] bad_byte
  output logic        m_tlast    // last_of_run
);

  logic   accept;
  logic   push, full, pop, empty;
  entry_t push_data, head;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  ots_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (s_tuser[0]),
    .source_byte (s_tdata),
    .push        (push),
    .push_data   (push_data)
  );

  ots_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (push_data),
    .full    (full),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (empty)
  );

  ots_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .rd_data  (head),
    .rd_en    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== hw/rtl/ots_front.sv =====
// Front end of the operator token scanner: accepts bytes, keeps the
// held-byte and garbage-run state, and builds the results of each item.
// Depends on ots_pkg.
module ots_front import ots_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       func,
  input  logic [7:0] source_byte,
  output logic       push,
  output entry_t     push_data
);

  offset_t     byte_offset, byte_offset_next;
  logic [7:0]  held_lead_byte, held_lead_byte_next;
  logic        held_valid, held_valid_next;
  logic        run_active, run_active_next;
  offset_t     run_start, run_start_next;
  logic [31:0] run_len, run_len_next;

  offset_t   hs;
  kind_hit_t alone_h, pair_h, fresh_h;
  logic      ha_v, run_v, fresh_v, garb;
  res_t      ha_r, run_r, fresh_r;

  always_comb begin
    hs      = byte_offset - OFF_ONE;
    alone_h = kind_alone(held_lead_byte);
    pair_h  = kind_pair(held_lead_byte, source_byte);
    fresh_h = kind_alone(source_byte);
    garb    = is_garbage(source_byte);

    run_r = '{kind: K_RUN, start: lo32(run_start), len: run_len, bad: 8'h00};

    ha_r  = '{kind: alone_h.kind, start: lo32(hs), len: 32'd1, bad: 8'h00};
    if (!func && pair_h.ok) begin
      ha_r.kind = pair_h.kind;
      ha_r.len  = 32'd2;
    end

    fresh_r = '{kind: fresh_h.kind, start: lo32(byte_offset), len: 32'd1,
                bad: (fresh_h.ok ? 8'h00 : source_byte)};

    byte_offset_next    = byte_offset;
    held_lead_byte_next = held_lead_byte;
    held_valid_next     = 1'b0;
    run_active_next     = run_active;
    run_start_next      = run_start;
    run_len_next        = run_len;
    ha_v    = held_valid;
    run_v   = 1'b0;
    fresh_v = 1'b0;

    if (func) begin
      run_v           = run_active;
      run_active_next = 1'b0;
      run_len_next    = '0;
    end else begin
      byte_offset_next = byte_offset + OFF_ONE;
      // a completed pair consumes the new byte
      if (!(held_valid && pair_h.ok)) begin
        if (garb) begin
          if (run_active) begin
            if (run_len != LEN_MAX) run_len_next = run_len + 32'd1;
          end else begin
            run_active_next = 1'b1;
            run_start_next  = byte_offset;
            run_len_next    = 32'd1;
          end
        end else begin
          run_v           = run_active;
          run_active_next = 1'b0;
          run_len_next    = '0;
          if (is_lead(source_byte)) begin
            held_lead_byte_next = source_byte;
            held_valid_next     = 1'b1;
          end else begin
            fresh_v = 1'b1;
          end
        end
      end
    end
  end

  // pack the first two results in order: held, run, fresh
  always_comb begin
    push_data = '{two: 1'b0, r0: fresh_r, r1: fresh_r};
    if (ha_v) begin
      push_data.r0 = ha_r;
      if (run_v) begin
        push_data.two = 1'b1;
        push_data.r1  = run_r;
      end else if (fresh_v) begin
        push_data.two = 1'b1;
      end
    end else if (run_v) begin
      push_data.r0 = run_r;
      push_data.two = fresh_v;
    end
    push = accept && (ha_v || run_v || fresh_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset    <= '0;
      held_lead_byte <= '0;
      held_valid     <= 1'b0;
      run_active     <= 1'b0;
      run_start      <= '0;
      run_len        <= '0;
    end else if (accept) begin
      byte_offset    <= byte_offset_next;
      held_lead_byte <= held_lead_byte_next;
      held_valid     <= held_valid_next;
      run_active     <= run_active_next;
      run_start      <= run_start_next;
      run_len        <= run_len_next;
    end
  end

endmodule

// ===== hw/rtl/ots_queue.sv =====
// Small result queue between the scanner front end and the output stage.
// Depends on ots_pkg.
module ots_queue import ots_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  entry_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   empty
);

  entry_t               mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;

  localparam logic [QPTR_BITS-1:0] PTR_LAST = QPTR_BITS'(QDEPTH - 1);
  localparam logic [QPTR_BITS-1:0] PTR_ONE  = QPTR_BITS'(1);
  localparam logic [QCNT_BITS-1:0] CNT_FULL = QCNT_BITS'(QDEPTH);
  localparam logic [QCNT_BITS-1:0] CNT_ONE  = QCNT_BITS'(1);

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_ONE;
      if (rd_en) rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_ONE;
      case ({wr_en, rd_en})
        2'b10:   count <= count + CNT_ONE;
        2'b01:   count <= count - CNT_ONE;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ots_emit.sv =====
// Output stage of the operator token scanner: takes one queue entry and
// sends its one or two results, marking the last with tlast.
// Depends on ots_pkg.
module ots_emit import ots_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  entry_t      rd_data,
  output logic        rd_en,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,
  output logic        m_tlast
);

  entry_t ent;
  logic   busy;
  logic   sel;
  res_t   cur;
  logic   take;

  always_comb begin
    cur      = sel ? ent.r1 : ent.r0;
    m_tlast  = sel || !ent.two;
    m_tvalid = busy;
    m_tdata  = {2'b00, cur.bad, cur.len, cur.start, cur.kind};
    take     = !busy || (m_tready && m_tlast);
    rd_en    = take && !empty;
  end

  always_ff @(posedge clk) begin
    if (rd_en) ent <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sel  <= 1'b0;
    end else if (take) begin
      busy <= !empty;
      sel  <= 1'b0;
    end else if (m_tready) begin
      sel <= 1'b1;
    end
  end

endmodule
